// ===== rtl/core/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// Shared page registry package
// Types, sizes and codes shared by the registry's interfaces and modules.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int ENTRIES    = 16;
    localparam int EIDX_W     = $clog2(ENTRIES);
    localparam int SLOTS      = 8;
    localparam int SIDX_W     = $clog2(SLOTS);
    localparam int PROCS      = 16;
    localparam int PROC_W     = $clog2(PROCS);
    localparam int GSLOT_W    = PROC_W + SIDX_W;
    localparam int GSLOTS     = PROCS * SLOTS;
    localparam int PAGE_SHIFT = 12;
    localparam int CNT_W      = EIDX_W + 1;

    typedef enum logic [1:0] {
        FUNC_GET     = 2'd0,
        FUNC_ATTACH  = 2'd1,
        FUNC_DETACH  = 2'd2,
        FUNC_CLEANUP = 2'd3
    } func_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_KEY   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_NO_SLOT   = 3'd4;
    localparam logic [2:0] ST_NO_MAP    = 3'd5;

    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         process_index;
        logic signed [31:0] lookup_key;
        logic [30:0]        object_id;
        logic [31:0]        user_address;
        logic [31:0]        new_frame;
        logic [15:0]        new_region;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [30:0] handle;
        logic [31:0] mapped_address;
        logic        map_request;
        logic [31:0] frame_out;
        logic        unmap_request;
        logic        release_request;
        logic [15:0] release_region;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [30:0] id;
        logic [30:0] key;
        logic [31:0] frame;
        logic [15:0] region;
        logic [7:0]  refs;
    } entry_t;

    typedef struct packed {
        logic [30:0] object;
        logic [31:0] address;
    } slot_t;

endpackage

// ===== rtl/core/spr_req_if.sv =====
// ----------------------------------------------------------------------------
// Registry request channel
// Valid/ready channel that carries one request item.
// ----------------------------------------------------------------------------
interface spr_req_if;
    logic          valid;
    logic          ready;
    spr_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/spr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Registry response channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface spr_rsp_if;
    logic          valid;
    logic          ready;
    spr_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/spr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/shared_page_registry_unit.sv =====
// ----------------------------------------------------------------------------
// Shared page registry unit
// Registry of shared page objects with per-process mapping slots.
// ----------------------------------------------------------------------------
// Requests arrive on cmd and results leave on rsp, both valid/ready; a
// transfer happens when valid and ready are high at a rising edge. user_base
// is written through cfg_wr_en/cfg_wr_data; the user must write it only while
// the unit is idle, as the unit itself does not enforce this.
// Objects live in a 16-entry RAM and mappings in a 128-slot RAM; valid bits
// are flip-flops, so reset clears both tables at once with no sweep.
// A get or attach walks the object RAM once, one entry a cycle; a get with a
// key of zero or less skips the walk. A detach walks the eight slots of its
// process and, when a mapping matches, then the object RAM. A cleanup removes
// the mappings of its process, lowest slot first, one result each; an empty
// cleanup gives no result. The walks go through the single read port of each
// RAM.
// One request is worked at a time; cmd.ready is high while no request is in
// work. Results sit in an output register, so a new request is taken while
// the last result still waits; a stalled rsp holds the unit at its next
// result until the transfer.
module shared_page_registry_unit (
    input  logic        clk,
    input  logic        rst_n,
    spr_req_if.sink     cmd,
    spr_rsp_if.source   rsp,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ESCAN  = 7'b0000010,
        S_SSCAN  = 7'b0000100,
        S_CNEXT  = 7'b0001000,
        S_CREAD  = 7'b0010000,
        S_ACT    = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t                          state_reg, state_next;
    spr_pkg::req_t                   req_reg, req_next;
    logic [spr_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            pend_reg, pend_next;
    logic [spr_pkg::EIDX_W-1:0]      chk_reg, chk_next;
    logic                            hit_reg, hit_next;
    logic [spr_pkg::EIDX_W-1:0]      hit_idx_reg, hit_idx_next;
    spr_pkg::entry_t                 hit_data_reg, hit_data_next;
    logic [spr_pkg::SIDX_W-1:0]      sidx_reg, sidx_next;
    spr_pkg::slot_t                  sdata_reg, sdata_next;
    logic [30:0]                     cmp_id_reg, cmp_id_next;
    spr_pkg::rsp_t                   res_reg, res_next;
    logic                            out_valid_reg, out_valid_next;
    spr_pkg::rsp_t                   out_data_reg, out_data_next;
    logic [31:0]                     user_base_reg;
    logic [30:0]                     next_id_reg, next_id_next;
    logic [spr_pkg::ENTRIES-1:0]     entry_valid_reg, entry_valid_next;
    logic [spr_pkg::GSLOTS-1:0]      slot_valid_reg, slot_valid_next;

    logic                            ent_we;
    logic [spr_pkg::EIDX_W-1:0]      ent_waddr;
    spr_pkg::entry_t                 ent_wdata;
    logic [$bits(spr_pkg::entry_t)-1:0] ent_rbits;
    spr_pkg::entry_t                 ent_rd;
    logic                            slot_we;
    logic [spr_pkg::GSLOT_W-1:0]     slot_waddr, slot_raddr;
    spr_pkg::slot_t                  slot_wdata;
    logic [$bits(spr_pkg::slot_t)-1:0] slot_rbits;
    spr_pkg::slot_t                  slot_rd;

    logic [spr_pkg::SLOTS-1:0]       proc_valid;
    logic [spr_pkg::GSLOT_W-1:0]     proc_base;
    logic                            free_slot_ok, used_slot_ok, free_ent_ok;
    logic [spr_pkg::SIDX_W-1:0]      free_slot, used_slot;
    logic [spr_pkg::EIDX_W-1:0]      free_ent;
    logic                            e_match, s_match;
    logic [31:0]                     slot_va;
    logic                            emit_ok;
    spr_pkg::rsp_t                   blank;

    spr_ram #(
        .WIDTH ($bits(spr_pkg::entry_t)),
        .DEPTH (spr_pkg::ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (cnt_reg[spr_pkg::EIDX_W-1:0]),
        .rdata (ent_rbits)
    );

    spr_ram #(
        .WIDTH ($bits(spr_pkg::slot_t)),
        .DEPTH (spr_pkg::GSLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rbits)
    );

    assign ent_rd  = spr_pkg::entry_t'(ent_rbits);
    assign slot_rd = spr_pkg::slot_t'(slot_rbits);

    assign cmd.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;
    assign emit_ok   = !out_valid_reg || rsp.ready;
    assign blank     = '0;

    assign proc_base  = {req_reg.process_index, {spr_pkg::SIDX_W{1'b0}}};
    assign proc_valid = slot_valid_reg[proc_base +: spr_pkg::SLOTS];

    always_comb
    begin
        free_slot_ok = 1'b0;
        used_slot_ok = 1'b0;
        free_slot    = '0;
        used_slot    = '0;
        for (int i = spr_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!proc_valid[i])
            begin
                free_slot_ok = 1'b1;
                free_slot    = spr_pkg::SIDX_W'(i);
            end
            if (proc_valid[i])
            begin
                used_slot_ok = 1'b1;
                used_slot    = spr_pkg::SIDX_W'(i);
            end
        end
        free_ent_ok = 1'b0;
        free_ent    = '0;
        for (int i = spr_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (!entry_valid_reg[i])
            begin
                free_ent_ok = 1'b1;
                free_ent    = spr_pkg::EIDX_W'(i);
            end
        end
    end

    assign slot_va = user_base_reg + (32'(free_slot) << spr_pkg::PAGE_SHIFT);

    // Scan compares use the data read for the index issued in the cycle before.
    assign e_match = pend_reg && entry_valid_reg[chk_reg] &&
                     ((req_reg.func == spr_pkg::FUNC_GET)
                        ? (ent_rd.key == req_reg.lookup_key[30:0])
                        : (ent_rd.id == cmp_id_reg));
    assign s_match = pend_reg &&
                     slot_valid_reg[{req_reg.process_index, chk_reg[spr_pkg::SIDX_W-1:0]}] &&
                     (slot_rd.address == req_reg.user_address);

    always_comb
    begin
        if (state_reg == S_CNEXT)
        begin
            slot_raddr = {req_reg.process_index, used_slot};
        end
        else
        begin
            slot_raddr = {req_reg.process_index, cnt_reg[spr_pkg::SIDX_W-1:0]};
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        cnt_next         = cnt_reg;
        pend_next        = 1'b0;
        chk_next         = chk_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        hit_data_next    = hit_data_reg;
        sidx_next        = sidx_reg;
        sdata_next       = sdata_reg;
        cmp_id_next      = cmp_id_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_data_next    = out_data_reg;
        next_id_next     = next_id_reg;
        entry_valid_next = entry_valid_reg;
        slot_valid_next  = slot_valid_reg;
        ent_we           = 1'b0;
        ent_waddr        = hit_idx_reg;
        ent_wdata        = hit_data_reg;
        slot_we          = 1'b0;
        slot_waddr       = {req_reg.process_index, free_slot};
        slot_wdata       = '{object: cmp_id_reg, address: slot_va};

        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (cmd.valid)
                begin
                    req_next    = cmd.data;
                    cmp_id_next = cmd.data.object_id;
                    case (spr_pkg::func_t'(cmd.data.func))
                        spr_pkg::FUNC_GET:
                        begin
                            if (cmd.data.lookup_key <= 0)
                            begin
                                res_next        = blank;
                                res_next.status = spr_pkg::ST_BAD_KEY;
                                res_next.last   = 1'b1;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_ESCAN;
                            end
                        end
                        spr_pkg::FUNC_ATTACH:  state_next = S_ESCAN;
                        spr_pkg::FUNC_DETACH:  state_next = S_SSCAN;
                        default:               state_next = S_CNEXT;
                    endcase
                end
            end

            S_ESCAN:
            begin
                if (cnt_reg < spr_pkg::CNT_W'(spr_pkg::ENTRIES))
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                    chk_next  = cnt_reg[spr_pkg::EIDX_W-1:0];
                end
                if (e_match)
                begin
                    hit_next      = 1'b1;
                    hit_idx_next  = chk_reg;
                    hit_data_next = ent_rd;
                    pend_next     = 1'b0;
                    state_next    = S_ACT;
                end
                else if (pend_reg && chk_reg == spr_pkg::EIDX_W'(spr_pkg::ENTRIES - 1))
                begin
                    hit_next   = 1'b0;
                    pend_next  = 1'b0;
                    state_next = S_ACT;
                end
            end

            S_SSCAN:
            begin
                if (cnt_reg < spr_pkg::CNT_W'(spr_pkg::SLOTS))
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                    chk_next  = spr_pkg::EIDX_W'(cnt_reg[spr_pkg::SIDX_W-1:0]);
                end
                if (s_match)
                begin
                    sidx_next   = chk_reg[spr_pkg::SIDX_W-1:0];
                    sdata_next  = slot_rd;
                    cmp_id_next = slot_rd.object;
                    cnt_next    = '0;
                    pend_next   = 1'b0;
                    state_next  = S_ESCAN;
                end
                else if (pend_reg &&
                         chk_reg[spr_pkg::SIDX_W-1:0] == spr_pkg::SIDX_W'(spr_pkg::SLOTS - 1))
                begin
                    res_next        = blank;
                    res_next.status = spr_pkg::ST_NO_MAP;
                    res_next.last   = 1'b1;
                    pend_next       = 1'b0;
                    state_next      = S_EMIT;
                end
            end

            S_CNEXT:
            begin
                if (used_slot_ok)
                begin
                    sidx_next  = used_slot;
                    state_next = S_CREAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_CREAD:
            begin
                sdata_next  = slot_rd;
                cmp_id_next = slot_rd.object;
                cnt_next    = '0;
                state_next  = S_ESCAN;
            end

            S_ACT:
            begin
                res_next      = blank;
                res_next.last = 1'b1;
                state_next    = S_EMIT;
                case (spr_pkg::func_t'(req_reg.func))
                    spr_pkg::FUNC_GET:
                    begin
                        if (hit_reg)
                        begin
                            res_next.handle = hit_data_reg.id;
                        end
                        else if (free_ent_ok)
                        begin
                            ent_we                     = 1'b1;
                            ent_waddr                  = free_ent;
                            ent_wdata                  = '{id: next_id_reg,
                                                           key: req_reg.lookup_key[30:0],
                                                           frame: req_reg.new_frame,
                                                           region: req_reg.new_region,
                                                           refs: 8'd0};
                            entry_valid_next[free_ent] = 1'b1;
                            res_next.handle            = next_id_reg;
                            // The id counter skips zero when it wraps.
                            next_id_next = (&next_id_reg) ? 31'd1 : next_id_reg + 31'd1;
                        end
                        else
                        begin
                            res_next.status = spr_pkg::ST_FULL;
                        end
                    end
                    spr_pkg::FUNC_ATTACH:
                    begin
                        if (!hit_reg)
                        begin
                            res_next.status = spr_pkg::ST_UNKNOWN;
                        end
                        else if (!free_slot_ok)
                        begin
                            res_next.status = spr_pkg::ST_NO_SLOT;
                        end
                        else
                        begin
                            slot_we                             = 1'b1;
                            slot_valid_next[proc_base + spr_pkg::GSLOT_W'(free_slot)] = 1'b1;
                            ent_we                              = 1'b1;
                            if (!(&hit_data_reg.refs))
                            begin
                                ent_wdata.refs = hit_data_reg.refs + 8'd1;
                            end
                            res_next.mapped_address = slot_va;
                            res_next.map_request    = 1'b1;
                            res_next.frame_out      = hit_data_reg.frame;
                        end
                    end
                    default:
                    begin
                        slot_valid_next[proc_base + spr_pkg::GSLOT_W'(sidx_reg)] = 1'b0;
                        res_next.mapped_address = sdata_reg.address;
                        res_next.unmap_request  = 1'b1;
                        if (hit_reg)
                        begin
                            if (hit_data_reg.refs <= 8'd1)
                            begin
                                entry_valid_next[hit_idx_reg] = 1'b0;
                                res_next.release_request      = 1'b1;
                                res_next.release_region       = hit_data_reg.region;
                            end
                            else
                            begin
                                ent_we         = 1'b1;
                                ent_wdata.refs = hit_data_reg.refs - 8'd1;
                            end
                        end
                        // Cleanup goes upwards, so only higher slots can remain.
                        if (req_reg.func == spr_pkg::FUNC_CLEANUP)
                        begin
                            res_next.last =
                                ((proc_valid & ~(spr_pkg::SLOTS'(1) << sidx_reg)) == '0);
                        end
                    end
                endcase
            end

            S_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    if (req_reg.func == spr_pkg::FUNC_CLEANUP && !res_reg.last)
                    begin
                        state_next = S_CNEXT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            user_base_reg   <= '0;
            next_id_reg     <= 31'd1;
            entry_valid_reg <= '0;
            slot_valid_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
            next_id_reg     <= next_id_next;
            entry_valid_reg <= entry_valid_next;
            slot_valid_reg  <= slot_valid_next;
            if (cfg_wr_en)
            begin
                user_base_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        cnt_reg      <= cnt_next;
        chk_reg      <= chk_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_data_reg <= hit_data_next;
        sidx_reg     <= sidx_next;
        sdata_reg    <= sdata_next;
        cmp_id_reg   <= cmp_id_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== sim/shared_page_registry_checker.sv =====
// ----------------------------------------------------------------------------
// Shared page registry checker
// Watches the request and response channels, predicts the results of every
// accepted request and compares them, field by field, in order.
// ----------------------------------------------------------------------------
module shared_page_registry_checker (
    input  logic        clk,
    input  logic        rst_n,
    spr_req_if          cmd,
    spr_rsp_if          rsp,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    output int          error_count,
    output int          pending_count
);

    localparam logic [30:0] ID_MAX = 31'h7FFF_FFFF;

    logic [31:0]     base_addr;
    logic            obj_valid [spr_pkg::ENTRIES];
    spr_pkg::entry_t obj       [spr_pkg::ENTRIES];
    logic [30:0]     id_counter;
    logic            map_valid [spr_pkg::GSLOTS];
    spr_pkg::slot_t  map_slot  [spr_pkg::GSLOTS];
    spr_pkg::rsp_t   expected_results [$];

    assign pending_count = expected_results.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what,
                 got, want);
        error_count++;
    endtask

    function automatic spr_pkg::rsp_t make_result(logic [2:0] st);
        spr_pkg::rsp_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic int find_object(logic [30:0] id);
        for (int i = 0; i < spr_pkg::ENTRIES; i++)
        begin
            if (obj_valid[i] && obj[i].id == id)
                return i;
        end
        return -1;
    endfunction

    function automatic spr_pkg::rsp_t unmap_slot(int g);
        spr_pkg::rsp_t r;
        int            e;
        r = make_result(spr_pkg::ST_OK);
        r.mapped_address = map_slot[g].address;
        r.unmap_request = 1'b1;
        e = find_object(map_slot[g].object);
        map_valid[g] = 1'b0;
        map_slot[g] = '0;
        if (e >= 0)
        begin
            if (obj[e].refs <= 1)
            begin
                r.release_request = 1'b1;
                r.release_region = obj[e].region;
                obj_valid[e] = 1'b0;
                obj[e] = '0;
            end
            else
            begin
                obj[e].refs--;
            end
        end
        return r;
    endfunction

    task automatic predict_request(input spr_pkg::req_t q);
        spr_pkg::rsp_t r;
        int            e;
        int            b;
        int            n;
        logic          done;
        b = int'(q.process_index) * spr_pkg::SLOTS;
        done = 1'b0;
        case (spr_pkg::func_t'(q.func))
            spr_pkg::FUNC_GET:
            begin
                if (q.lookup_key <= 0)
                begin
                    expected_results.push_back(make_result(spr_pkg::ST_BAD_KEY));
                end
                else
                begin
                    for (int i = 0; i < spr_pkg::ENTRIES && !done; i++)
                    begin
                        if (obj_valid[i] && obj[i].key == q.lookup_key[30:0])
                        begin
                            r = make_result(spr_pkg::ST_OK);
                            r.handle = obj[i].id;
                            expected_results.push_back(r);
                            done = 1'b1;
                        end
                    end
                    for (int i = 0; i < spr_pkg::ENTRIES && !done; i++)
                    begin
                        if (!obj_valid[i])
                        begin
                            obj_valid[i] = 1'b1;
                            obj[i] = '{id: id_counter, key: q.lookup_key[30:0],
                                       frame: q.new_frame, region: q.new_region,
                                       refs: 8'd0};
                            r = make_result(spr_pkg::ST_OK);
                            r.handle = id_counter;
                            expected_results.push_back(r);
                            id_counter = (id_counter == ID_MAX) ? 31'd1
                                                                : id_counter + 31'd1;
                            done = 1'b1;
                        end
                    end
                    if (!done)
                        expected_results.push_back(make_result(spr_pkg::ST_FULL));
                end
            end
            spr_pkg::FUNC_ATTACH:
            begin
                e = find_object(q.object_id);
                if (e < 0)
                begin
                    expected_results.push_back(make_result(spr_pkg::ST_UNKNOWN));
                end
                else
                begin
                    for (int i = 0; i < spr_pkg::SLOTS && !done; i++)
                    begin
                        if (!map_valid[b + i])
                        begin
                            r = make_result(spr_pkg::ST_OK);
                            r.mapped_address = base_addr + 32'(i) * 32'd4096;
                            r.map_request = 1'b1;
                            r.frame_out = obj[e].frame;
                            map_valid[b + i] = 1'b1;
                            map_slot[b + i] = '{object: q.object_id,
                                                address: r.mapped_address};
                            if (obj[e].refs != 8'hFF)
                                obj[e].refs++;
                            expected_results.push_back(r);
                            done = 1'b1;
                        end
                    end
                    if (!done)
                        expected_results.push_back(make_result(spr_pkg::ST_NO_SLOT));
                end
            end
            spr_pkg::FUNC_DETACH:
            begin
                for (int i = 0; i < spr_pkg::SLOTS && !done; i++)
                begin
                    if (map_valid[b + i] && map_slot[b + i].address == q.user_address)
                    begin
                        expected_results.push_back(unmap_slot(b + i));
                        done = 1'b1;
                    end
                end
                if (!done)
                    expected_results.push_back(make_result(spr_pkg::ST_NO_MAP));
            end
            default:
            begin
                n = 0;
                for (int i = 0; i < spr_pkg::SLOTS; i++)
                begin
                    if (map_valid[b + i])
                    begin
                        if (n > 0)
                            expected_results[$].last = 1'b0;
                        expected_results.push_back(unmap_slot(b + i));
                        n++;
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        spr_pkg::rsp_t got;
        spr_pkg::rsp_t want;
        if (!rst_n)
        begin
            base_addr <= '0;
            id_counter = 31'd1;
            for (int i = 0; i < spr_pkg::ENTRIES; i++)
            begin
                obj_valid[i] = 1'b0;
                obj[i] = '0;
            end
            for (int i = 0; i < spr_pkg::GSLOTS; i++)
            begin
                map_valid[i] = 1'b0;
                map_slot[i] = '0;
            end
            expected_results.delete();
            error_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
                base_addr <= cfg_wr_data;
            // The response is checked before the request of the same edge is predicted.
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.data;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected", $realtime);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.handle != want.handle)
                        report_mismatch("handle", got.handle, want.handle);
                    if (got.mapped_address != want.mapped_address)
                        report_mismatch("mapped_address", got.mapped_address,
                                        want.mapped_address);
                    if (got.map_request != want.map_request)
                        report_mismatch("map_request", got.map_request, want.map_request);
                    if (got.frame_out != want.frame_out)
                        report_mismatch("frame_out", got.frame_out, want.frame_out);
                    if (got.unmap_request != want.unmap_request)
                        report_mismatch("unmap_request", got.unmap_request,
                                        want.unmap_request);
                    if (got.release_request != want.release_request)
                        report_mismatch("release_request", got.release_request,
                                        want.release_request);
                    if (got.release_region != want.release_region)
                        report_mismatch("release_region", got.release_region,
                                        want.release_region);
                    if (got.last != want.last)
                        report_mismatch("last", got.last, want.last);
                end
            end
            if (cmd.valid && cmd.ready)
                predict_request(cmd.data);
        end
    end

endmodule

// ===== sim/shared_page_registry_unit_test.sv =====
// ----------------------------------------------------------------------------
// Shared page registry unit testbench
// Drives directed and random registry requests under varying back-pressure;
// the checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module shared_page_registry_unit_test;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    int          error_count;
    int          pending_count;
    int          send_idle_pct;
    int          take_idle_pct;
    logic        stall_go;
    logic        hold_active;
    logic [31:0] cur_base;

    spr_req_if cmd ();
    spr_rsp_if rsp ();

    shared_page_registry_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    shared_page_registry_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rsp           (rsp),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // The long receiver stall is counted here once the stimulus asks for it.
    initial
    begin
        hold_active = 1'b0;
        wait (stall_go === 1'b1);
        hold_active = 1'b1;
        repeat (400) @(posedge clk);
        hold_active = 1'b0;
    end

    // The receiver stalls at random, or for the long stretch above.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else if (hold_active)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // The request stays offered after its transfer; the next call or
    // stop_sending takes it back in the same time step.
    task automatic send_request(input spr_pkg::req_t q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.data <= q;
        do
            @(posedge clk);
        while (!cmd.ready);
    endtask

    task automatic stop_sending();
        cmd.valid <= 1'b0;
    endtask

    function automatic spr_pkg::req_t random_fields();
        spr_pkg::req_t q;
        q.func = 2'($urandom());
        q.process_index = 4'($urandom());
        q.lookup_key = $urandom();
        q.object_id = 31'($urandom());
        q.user_address = $urandom();
        q.new_frame = $urandom();
        q.new_region = 16'($urandom());
        return q;
    endfunction

    function automatic spr_pkg::req_t make_get(logic signed [31:0] key);
        spr_pkg::req_t q;
        q = random_fields();
        q.func = spr_pkg::FUNC_GET;
        q.lookup_key = key;
        return q;
    endfunction

    function automatic spr_pkg::req_t make_op(spr_pkg::func_t f, logic [3:0] p,
                                               logic [30:0] id, logic [31:0] addr);
        spr_pkg::req_t q;
        q = random_fields();
        q.func = f;
        q.process_index = p;
        q.object_id = id;
        q.user_address = addr;
        return q;
    endfunction

    // Waits until every result has gone and the unit is idle again.
    task automatic wait_quiet();
        stop_sending();
        @(posedge clk);
        // A cleanup with no mappings leaves nothing expected but may still be walking.
        while (pending_count != 0 || !cmd.ready)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic drain_and_write(input logic [31:0] value);
        wait_quiet();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_base = value;
    endtask

    // Mostly keys from a small pool so that gets hit, attaches find objects and
    // detaches find mappings.
    task automatic random_phase(input int count);
        spr_pkg::req_t q;
        int            pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                q = make_get($urandom_range(1, 24));
                if ($urandom_range(9) == 0)
                    q.lookup_key = $urandom();
            end
            else if (pick < 55)
            begin
                q = make_op(spr_pkg::FUNC_ATTACH, 4'($urandom_range(3)),
                            31'($urandom_range(1, 40)), 32'd0);
                if ($urandom_range(9) == 0)
                    q.object_id = 31'($urandom());
            end
            else if (pick < 85)
            begin
                q = make_op(spr_pkg::FUNC_DETACH, 4'($urandom_range(3)), 31'd0,
                            cur_base + 32'($urandom_range(8)) * 32'd4096);
                if ($urandom_range(9) == 0)
                    q.user_address = $urandom();
            end
            else if (pick < 93)
            begin
                q = make_op(spr_pkg::FUNC_CLEANUP, 4'($urandom_range(3)), 31'd0, 32'd0);
            end
            else
            begin
                q = random_fields();
            end
            send_request(q);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd.valid = 1'b0;
        cmd.data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        stall_go = 1'b0;
        cur_base = '0;
        send_idle_pct = 26;
        take_idle_pct = 80;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        drain_and_write(32'hFFFF_E000);
        // Directed: key extremes, table fill and overflow, slot exhaustion,
        // address wrap, duplicate detach, unknown ids and cleanups.
        send_request(make_get(32'sh8000_0000));
        send_request(make_get(32'sd0));
        send_request(make_get(-32'sd1));
        send_request(make_get(32'sh7FFF_FFFF));
        send_request(make_op(spr_pkg::FUNC_ATTACH, 4'd15, 31'd0, 32'd0));
        send_request(make_op(spr_pkg::FUNC_ATTACH, 4'd15, 31'h7FFF_FFFF, 32'd0));
        for (int i = 0; i < 9; i++)
            send_request(make_op(spr_pkg::FUNC_ATTACH, 4'd15, 31'd1, 32'd0));
        send_request(make_op(spr_pkg::FUNC_DETACH, 4'd15, 31'd0, 32'hFFFF_E000));
        send_request(make_op(spr_pkg::FUNC_DETACH, 4'd15, 31'd0, 32'hFFFF_E000));
        send_request(make_op(spr_pkg::FUNC_DETACH, 4'd0, 31'd0, 32'h0000_0000));
        send_request(make_op(spr_pkg::FUNC_CLEANUP, 4'd15, 31'd0, 32'd0));
        send_request(make_op(spr_pkg::FUNC_CLEANUP, 4'd15, 31'd0, 32'd0));
        for (int i = 2; i < 19; i++)
            send_request(make_get(i));

        // Long receiver stall while requests keep coming.
        stall_go = 1'b1;
        for (int i = 0; i < 8; i++)
            send_request(make_op(spr_pkg::FUNC_ATTACH, 4'd2, 31'd2, 32'd0));
        send_request(make_op(spr_pkg::FUNC_CLEANUP, 4'd2, 31'd0, 32'd0));

        // Empty the table again before the random part.
        for (int p = 0; p < spr_pkg::PROCS; p++)
            send_request(make_op(spr_pkg::FUNC_CLEANUP, 4'(p), 31'd0, 32'd0));
        drain_and_write(32'h0000_0000);
        for (int i = 2; i < 18; i++)
        begin
            send_request(make_op(spr_pkg::FUNC_ATTACH, 4'd0, 31'(i), 32'd0));
            send_request(make_op(spr_pkg::FUNC_DETACH, 4'd0, 31'd0, 32'h0));
        end
        random_phase(35);

        send_idle_pct = 80;
        take_idle_pct = 26;
        drain_and_write($urandom());
        random_phase(35);

        send_idle_pct = 0;
        take_idle_pct = 0;
        drain_and_write(32'hFFFF_FFFF);
        random_phase(35);

        wait_quiet();
        if (error_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== shared_page_registry_unit.f =====
rtl/core/spr_pkg.sv
rtl/core/spr_req_if.sv
rtl/core/spr_rsp_if.sv
rtl/core/spr_ram.sv
rtl/core/shared_page_registry_unit.sv
sim/shared_page_registry_checker.sv
sim/shared_page_registry_unit_test.sv
